/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FRCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frct assertion failed");
// condition must never hold
`define FRCT_ASSERT_NEVER(label, cond) `FRCT_ASSERT(label, !(cond))
`else
`define FRCT_ASSERT(label, prop)
`define FRCT_ASSERT_NEVER(label, cond)
`endif
`endif

/* src/frct_pkg.sv */
// ----------------------------------------------------------------------------
// frct_pkg
// Shared types, widths and codes of the free range coalescing table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frct_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int PAGE_SHIFT_DEF  = 12;

  localparam int KIND_W   = 2;
  localparam int TYPE_W   = 5;
  localparam int START_W  = 52;
  localparam int PAGES_W  = 40;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int BASE_W   = 52;
  localparam int LEN_W    = 53;
  localparam int CNT_W    = 7;
  localparam int MASK_W   = 32;

  localparam int APB_DW = 64;
  localparam int APB_AW = 4;

  localparam logic [BASE_W-1:0] FLOOR_RST = BASE_W'(64'h10_0000);
  localparam logic [MASK_W-1:0] MASK_RST  = MASK_W'(158);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MERGED    = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_TYPE_SKIP = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_READ_OOR  = 3'd6,
    ST_CLEARED   = 3'd7
  } status_e;

  typedef enum logic {
    REG_FLOOR     = 1'b0,
    REG_TYPE_MASK = 1'b1
  } reg_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TYPE_W-1:0]  mem_type;
    logic [START_W-1:0] phys_start;
    logic [PAGES_W-1:0] page_count;
    logic [IDX_W-1:0]   read_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    entry_index;
    logic [BASE_W-1:0]   entry_base;
    logic [LEN_W-1:0]    entry_length;
    logic [CNT_W-1:0]    entry_count;
  } rsp_t;

  // request token walking down the cell chain
  typedef struct packed {
    logic               valid;
    logic               is_read;
    logic               hit;
    logic               appended;
    logic [BASE_W-1:0]  start;
    logic [LEN_W-1:0]   range_end;
    logic [IDX_W-1:0]   read_idx;
    logic [IDX_W-1:0]   idx;
    logic [BASE_W-1:0]  base;
    logic [LEN_W-1:0]   length;
  } token_t;

endpackage

/* src/frct_req_if.sv */
// ----------------------------------------------------------------------------
// frct_req_if
// Valid/ready channel carrying requests into the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frct_req_if;
  logic           valid;
  logic           ready;
  frct_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/frct_rsp_if.sv */
// ----------------------------------------------------------------------------
// frct_rsp_if
// Valid/ready channel carrying results out of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frct_rsp_if;
  logic           valid;
  logic           ready;
  frct_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/frct_cell.sv */
// ----------------------------------------------------------------------------
// frct_cell
// One table entry: checks the passing token against its range, merges,
// appends or returns its entry, and hands the token on in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frct_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CW-1:0]    count_i,
  input  frct_pkg::token_t tok_i,
  output frct_pkg::token_t tok_o
);
  import frct_pkg::*;

  localparam logic [CW-1:0]    MyIdx    = CW'(IDX);
  localparam logic [IDX_W-1:0] MyTag    = IDX_W'(IDX);
  localparam logic             Readable = (IDX < (1 << IDX_W));

  logic [BASE_W-1:0] base_q;
  logic [LEN_W-1:0]  len_q;
  token_t            tok_d, tok_q;

  logic [LEN_W:0]    cur_end, new_end, new_start_x, tok_start_x, tok_end_x, diff;
  logic [BASE_W-1:0] new_start;
  logic              live, overlap, wr_merge, wr_app;

  always_comb begin
    cur_end     = {2'b00, base_q} + {1'b0, len_q};
    tok_start_x = {2'b00, tok_i.start};
    tok_end_x   = {1'b0, tok_i.range_end};
    live        = (MyIdx < count_i);
    overlap     = !((cur_end < tok_start_x) || (tok_end_x < {2'b00, base_q}));
    new_end     = (tok_end_x > cur_end) ? tok_end_x : cur_end;
    new_start   = (tok_i.start < base_q) ? tok_i.start : base_q;
    new_start_x = {2'b00, new_start};
    diff        = new_end - new_start_x;

    tok_d    = tok_i;
    wr_merge = 1'b0;
    wr_app   = 1'b0;
    if (tok_i.valid && !tok_i.hit) begin
      if (tok_i.is_read) begin
        if (Readable && live && (tok_i.read_idx == MyTag)) begin
          tok_d.hit    = 1'b1;
          tok_d.idx    = MyTag;
          tok_d.base   = base_q;
          tok_d.length = len_q;
        end
      end else if (live && overlap) begin
        wr_merge     = 1'b1;
        tok_d.hit    = 1'b1;
        tok_d.idx    = MyTag;
        tok_d.base   = new_start;
        tok_d.length = diff[LEN_W-1:0];
      end else if (MyIdx == count_i) begin
        // first free slot and nothing matched above: append here
        wr_app         = 1'b1;
        tok_d.hit      = 1'b1;
        tok_d.appended = 1'b1;
        tok_d.idx      = MyTag;
        tok_d.base     = tok_i.start;
        tok_d.length   = tok_i.range_end - {1'b0, tok_i.start};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_merge || wr_app) begin
      base_q <= tok_d.base;
      len_q  <= tok_d.length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* src/free_range_coalescing_table.sv */
// ----------------------------------------------------------------------------
// free_range_coalescing_table
// Coalesces firmware memory descriptors into a table of usable ranges.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per handshake: insert a descriptor, read one
//   entry, or clear the table. rsp_o returns exactly one result per request
//   (kind 3 is dropped without a result). The APB port sets the floor address
//   (0x0) and type mask (0x8); the user must write them only while no request
//   is in flight; the block itself does not enforce this.
// Processing:
//   clear and type-skipped inserts give their result from the CALC state,
//   empty inserts from the CHECK state; reads and other inserts send a token
//   down the chain of MAX_ENTRIES entry cells, one cell per cycle; the result
//   is registered when the token leaves the last cell. One request is handled
//   at a time; the next is accepted at the edge that takes the result.
// Reset: the table is empty and the registers hold their defaults; entry
//   contents are not cleared since the count masks them.
// Stall: a result sits in the output register until taken; no new request
//   is accepted while it is held and not being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module free_range_coalescing_table #(
  parameter int MAX_ENTRIES = frct_pkg::MAX_ENTRIES_DEF,
  parameter int PAGE_SHIFT  = frct_pkg::PAGE_SHIFT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  frct_req_if.sink                    req_i,
  frct_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frct_pkg::APB_AW-1:0] paddr,
  input  logic [frct_pkg::APB_DW-1:0] pwdata,
  output logic [frct_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import frct_pkg::*;

`include "assert_macros.svh"

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int SpW  = PAGES_W + PAGE_SHIFT;
  localparam int SumW = ((SpW > START_W) ? SpW : START_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_CHECK, S_WALK} state_e;

  state_e            state_q;
  logic [BASE_W-1:0] floor_q;
  logic [MASK_W-1:0] type_mask_q;
  logic [CW-1:0]     count_q;
  logic              out_valid_q;
  rsp_t              out_q;
  rsp_t              out_d;
  logic              out_load;
  req_t              item_q;
  logic [BASE_W-1:0] start_q;
  logic [LEN_W-1:0]  end_q;

  token_t            tok [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:1] tok_vld;
  token_t            last;

  logic [SumW-1:0]   sum;
  logic [LEN_W-1:0]  end_sat;
  logic [BASE_W-1:0] start_raised;
  logic              type_ok, empty, accept, cfg_wr;
  logic [CW-1:0]     count_inc;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q     <= FLOOR_RST;
      type_mask_q <= MASK_RST;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3]))
        REG_FLOOR:     floor_q     <= pwdata[BASE_W-1:0];
        REG_TYPE_MASK: type_mask_q <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3]))
      REG_FLOOR:     prdata = APB_DW'(floor_q);
      REG_TYPE_MASK: prdata = APB_DW'(type_mask_q);
      default:       prdata = '0;
    endcase
  end

  // request handshake
  assign req_i.ready   = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // range end with saturation, start raised to the floor
  always_comb begin
    sum          = SumW'(item_q.phys_start) + (SumW'(item_q.page_count) << PAGE_SHIFT);
    end_sat      = (sum > SumW'({LEN_W{1'b1}})) ? '1 : sum[LEN_W-1:0];
    start_raised = (item_q.phys_start < floor_q) ? floor_q : item_q.phys_start;
    type_ok      = type_mask_q[item_q.mem_type];
    empty        = ({1'b0, start_q} >= end_q);
    count_inc    = count_q + CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i.payload;
    end
    if (state_q == S_CALC) begin
      start_q <= start_raised;
      end_q   <= end_sat;
    end
  end

  // launch into the first cell
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = ((state_q == S_CALC) && (item_q.kind == KIND_READ)) ||
                      ((state_q == S_CHECK) && !empty);
    tok[0].is_read  = (item_q.kind == KIND_READ);
    tok[0].start    = start_q;
    tok[0].range_end = end_q;
    tok[0].read_idx = item_q.read_index;
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    frct_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1])
    );
    assign tok_vld[k+1] = tok[k+1].valid;
  end

  assign last = tok[MAX_ENTRIES];

  // result of the request that finishes in this cycle
  always_comb begin
    out_load          = 1'b0;
    out_d             = '0;
    out_d.entry_count = CNT_W'(count_q);
    case (state_q)
      S_CALC: begin
        if (item_q.kind == KIND_CLEAR) begin
          out_load          = 1'b1;
          out_d.status      = ST_CLEARED;
          out_d.entry_count = '0;
        end else if ((item_q.kind == KIND_INSERT) && !type_ok) begin
          out_load     = 1'b1;
          out_d.status = ST_TYPE_SKIP;
        end
      end
      S_CHECK: begin
        if (empty) begin
          out_load     = 1'b1;
          out_d.status = ST_EMPTY;
        end
      end
      S_WALK: begin
        if (last.valid) begin
          out_load = 1'b1;
          if (last.is_read) begin
            out_d.entry_index = last.read_idx;
            if (last.hit) begin
              out_d.status       = ST_READ_OK;
              out_d.entry_base   = last.base;
              out_d.entry_length = last.length;
            end else begin
              out_d.status = ST_READ_OOR;
            end
          end else if (last.hit) begin
            out_d.entry_index  = last.idx;
            out_d.entry_base   = last.base;
            out_d.entry_length = last.length;
            if (last.appended) begin
              out_d.status      = ST_APPENDED;
              out_d.entry_count = CNT_W'(count_inc);
            end else begin
              out_d.status = ST_MERGED;
            end
          end else begin
            out_d.status = ST_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          case (item_q.kind)
            KIND_CLEAR: begin
              count_q <= '0;
              state_q <= S_IDLE;
            end
            KIND_READ: state_q <= S_WALK;
            KIND_INSERT: begin
              if (!type_ok) begin
                state_q <= S_IDLE;
              end else begin
                state_q <= S_CHECK;
              end
            end
            // undefined kind: drop without a result
            default: state_q <= S_IDLE;
          endcase
        end
        S_CHECK: begin
          if (empty) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (last.valid) begin
            if (!last.is_read && last.hit && last.appended) begin
              count_q <= count_inc;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `FRCT_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES))
  `FRCT_ASSERT(a_single_token, $onehot0(tok_vld))
  `FRCT_ASSERT_NEVER(a_token_outside_walk, (tok_vld != '0) && (state_q != S_WALK))
  `FRCT_ASSERT(a_count_hold, (state_q == S_IDLE || state_q == S_CHECK) |=> $stable(count_q))

endmodule
